// ===== rtl/fdmd_pkg.sv =====
// Package for the fixed-point decimal multiply/divide unit.
// Holds the scale constant, widths and the status code type; no dependencies.
package fdmd_pkg;

  localparam int unsigned WordW = 128;
  localparam int unsigned ProdW = 256;
  localparam int unsigned DivSteps = 256;

  localparam logic [WordW-1:0] ScaleK = 128'd1000000000000000000;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StOverflow = 2'd1,
    StDivZero  = 2'd2
  } status_e;

  typedef struct packed {
    logic  valid;
    logic  neg;
    logic  dz;
    word_t d;
  } div_ctl_t;

endpackage

// ===== rtl/fdmd_div_stage.sv =====
// One restoring division step: one quotient bit per stage, registered.
// Depends on fdmd_pkg.
module fdmd_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  fdmd_pkg::div_ctl_t ctl_i,
  input  fdmd_pkg::word_t    rem_i,
  input  fdmd_pkg::prod_t    num_i,
  output fdmd_pkg::div_ctl_t ctl_o,
  output fdmd_pkg::word_t    rem_o,
  output fdmd_pkg::prod_t    num_o
);
  import fdmd_pkg::*;

  logic [WordW:0]   trial;
  logic [WordW:0]   diff;
  logic             take;
  logic             valid_q;
  div_ctl_t         ctl_q;
  word_t            rem_d, rem_q;
  prod_t            num_d, num_q;

  always_comb begin
    trial = {rem_i, num_i[ProdW-1]};
    diff  = trial - {1'b0, ctl_i.d};
    take  = (trial >= {1'b0, ctl_i.d});
    rem_d = take ? diff[WordW-1:0] : trial[WordW-1:0];
    num_d = {num_i[ProdW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      num_q <= num_d;
    end
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = valid_q;
  end
  assign rem_o = rem_q;
  assign num_o = num_q;

endmodule

// ===== rtl/fixed_decimal_mul_div_unit.sv =====
// Fixed-point decimal (scale 10^18) 128-bit multiply/divide, fully pipelined.
// The path from the inputs to out_valid_o runs over 261 register stages:
// magnitudes, 32x32 partial products, two summing stages, 256 one-bit restoring
// division stages, result stage. Throughput one request per cycle; the whole
// pipeline holds while the output register is stalled.
// Reset (rst_ni, asynchronous, active low) clears all valid bits.
module fixed_decimal_mul_div_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         opcode_i,
  input  logic signed [63:0] a_high_i,
  input  logic [63:0]  a_low_i,
  input  logic signed [63:0] b_high_i,
  input  logic [63:0]  b_low_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [1:0]   status_o,
  output logic signed [63:0] result_high_o,
  output logic [63:0]  result_low_o,
  output logic signed [63:0] remainder_high_o,
  output logic [63:0]  remainder_low_o,
  output logic signed [63:0] overflow_high_o,
  output logic [63:0]  overflow_low_o
);
  import fdmd_pkg::*;

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // stage 1: magnitudes and operand selection
  word_t a_raw, b_raw, a_mag, b_mag;
  logic  a_neg, b_neg;
  logic  v1_q, neg1_q, dz1_q;
  word_t am1_q, bm1_q, d1_q;

  always_comb begin
    a_raw = {a_high_i, a_low_i};
    b_raw = {b_high_i, b_low_i};
    a_neg = a_raw[WordW-1];
    b_neg = b_raw[WordW-1];
    a_mag = a_neg ? (~a_raw + word_t'(1)) : a_raw;
    b_mag = b_neg ? (~b_raw + word_t'(1)) : b_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= a_neg ^ b_neg;
      dz1_q  <= opcode_i && (b_mag == '0);
      am1_q  <= a_mag;
      bm1_q  <= opcode_i ? ScaleK : b_mag;
      d1_q   <= opcode_i ? b_mag : ScaleK;
    end
  end

  // stage 2: sixteen 32x32 partial products
  logic        v2_q, neg2_q, dz2_q;
  word_t       d2_q;
  logic [63:0] pp2_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg2_q <= neg1_q;
      dz2_q  <= dz1_q;
      d2_q   <= d1_q;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp2_q[i*4+j] <= am1_q[i*32 +: 32] * bm1_q[j*32 +: 32];
        end
      end
    end
  end

  // stage 3: row sums
  logic         v3_q, neg3_q, dz3_q;
  word_t        d3_q;
  logic [191:0] row3_d [4];
  logic [191:0] row3_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row3_d[i] = {128'd0, pp2_q[i*4]} + {96'd0, pp2_q[i*4+1], 32'd0}
                + {64'd0, pp2_q[i*4+2], 64'd0} + {32'd0, pp2_q[i*4+3], 96'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg3_q <= neg2_q;
      dz3_q  <= dz2_q;
      d3_q   <= d2_q;
      for (int i = 0; i < 4; i++) begin
        row3_q[i] <= row3_d[i];
      end
    end
  end

  // stage 4: full product
  div_ctl_t ctl4;
  logic     v4_q, neg4_q, dz4_q;
  word_t    d4_q;
  prod_t    n4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q <= neg3_q;
      dz4_q  <= dz3_q;
      d4_q   <= d3_q;
      n4_q   <= {64'd0, row3_q[0]} + {32'd0, row3_q[1], 32'd0}
              + {row3_q[2], 64'd0} + {row3_q[3][159:0], 96'd0};
    end
  end

  always_comb begin
    ctl4.valid = v4_q;
    ctl4.neg   = neg4_q;
    ctl4.dz    = dz4_q;
    ctl4.d     = d4_q;
  end

  // division chain
  div_ctl_t ctl_s [DivSteps+1];
  word_t    rem_s [DivSteps+1];
  prod_t    num_s [DivSteps+1];

  assign ctl_s[0] = ctl4;
  assign rem_s[0] = '0;
  assign num_s[0] = n4_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    fdmd_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_s[k]),
      .rem_i  (rem_s[k]),
      .num_i  (num_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .num_o  (num_s[k+1])
    );
  end

  // result stage
  div_ctl_t fin;
  prod_t    q;
  word_t    rem_f, res_f, ovf_f, res_o_d, rem_o_d, ovf_o_d;
  logic     over;
  status_e  st_d;
  logic     vo_q;
  status_e  st_q;
  word_t    res_q, rem_q, ovf_q;

  always_comb begin
    fin   = ctl_s[DivSteps];
    q     = num_s[DivSteps];
    rem_f = rem_s[DivSteps];
    over  = (q[ProdW-1:WordW-1] != '0);
    res_f = {1'b0, q[WordW-2:0]};
    if (q[ProdW-1:WordW] != '0) begin
      ovf_f = q[ProdW-1:WordW];
    end else begin
      ovf_f = over ? word_t'(1) : '0;
    end
    res_o_d = fin.neg ? (~res_f + word_t'(1)) : res_f;
    rem_o_d = fin.neg ? (~rem_f + word_t'(1)) : rem_f;
    ovf_o_d = fin.neg ? (~ovf_f + word_t'(1)) : ovf_f;
    st_d    = over ? StOverflow : StOk;
    if (fin.dz) begin
      res_o_d = '0;
      rem_o_d = '0;
      ovf_o_d = '0;
      st_d    = StDivZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q  <= st_d;
      res_q <= res_o_d;
      rem_q <= rem_o_d;
      ovf_q <= ovf_o_d;
    end
  end

  assign out_valid_o      = vo_q;
  assign status_o         = st_q;
  assign result_high_o    = res_q[127:64];
  assign result_low_o     = res_q[63:0];
  assign remainder_high_o = rem_q[127:64];
  assign remainder_low_o  = rem_q[63:0];
  assign overflow_high_o  = ovf_q[127:64];
  assign overflow_low_o   = ovf_q[63:0];

endmodule
